// File: hdl/cnv_pkg.sv
// shared types and constants for the convolution line buffer
`timescale 1ns / 1ps
`default_nettype none
package cnv_pkg;

  // action codes of an input request
  localparam logic [1:0] ACT_PIXEL  = 2'd0;
  localparam logic [1:0] ACT_WEIGHT = 2'd1;
  localparam logic [1:0] ACT_BIAS   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  address;
    logic [15:0] value;
    logic        window_ok;
    logic        image_end;
  } cmd_t;

  // floor(p / 2^11) to 16 bits, for a 32-bit signed product
  function automatic logic [15:0] trunc_q(input logic signed [31:0] p);
    logic [31:0] q;
    q = 32'(p >>> 11);
    return q[15:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/cnv_front.sv
// front end: accepts requests, tracks raster position and classifies them
`timescale 1ns / 1ps
`default_nettype none
module cnv_front import cnv_pkg::*; #(
  parameter int IMAGE_WIDTH = 32,
  parameter int CHANNELS    = 1,
  parameter int KERNEL      = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,
  input  wire logic [25:0] in_tdata,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_t             q_cmd
);

  localparam int PW = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [PW-1:0] row_r, col_r;
  logic [CW-1:0] chan_r;
  logic          take;
  logic          pixel;

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign take      = in_tvalid && in_tready;
  assign pixel     = (in_tuser == ACT_PIXEL);

  // classify the request against the current raster position
  always_comb begin
    q_cmd.action    = in_tuser;
    q_cmd.address   = in_tdata[9:0];
    q_cmd.value     = in_tdata[25:10];
    q_cmd.window_ok = pixel && (32'(row_r) >= 32'(KERNEL - 1)) &&
                      (32'(col_r) >= 32'(KERNEL - 1)) && (32'(chan_r) == 32'(CHANNELS - 1));
    q_cmd.image_end = (32'(row_r) == 32'(IMAGE_WIDTH - 1)) &&
                      (32'(col_r) == 32'(IMAGE_WIDTH - 1));
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; chan_r <= '0;
    end else if (take && pixel) begin
      if (32'(chan_r) == 32'(CHANNELS - 1)) begin
        chan_r <= '0;
        if (32'(col_r) == 32'(IMAGE_WIDTH - 1)) begin
          col_r <= '0;
          if (32'(row_r) == 32'(IMAGE_WIDTH - 1)) row_r <= '0;
          else row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else begin
        chan_r <= chan_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/cnv_fifo.sv
// short queue of classified commands between front and back
`timescale 1ns / 1ps
`default_nettype none
module cnv_fifo import cnv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  cmd_t      wr_cmd,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_cmd
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

// File: hdl/cnv_back.sv
// back end: line buffer, coefficient stores and per-filter mac sequencer
`timescale 1ns / 1ps
`default_nettype none
module cnv_back import cnv_pkg::*; #(
  parameter int IMAGE_WIDTH = 32,
  parameter int KERNEL      = 3,
  parameter int CHANNELS    = 1,
  parameter int FILTERS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        c_valid,
  output logic             c_ready,
  input  cmd_t             c_cmd,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // window_last [0], image_last [1]
  output logic [17:0]      out_tdata   // result [14:0], filter_index [17:15]
);

  localparam int LINE_DEPTH = (IMAGE_WIDTH * (KERNEL - 1) + KERNEL) * CHANNELS;
  localparam int TAPS       = KERNEL * KERNEL * CHANNELS;
  localparam int WDEPTH     = TAPS * FILTERS;
  localparam int FW         = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int TW         = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int WW         = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int NW         = $clog2(LINE_DEPTH + 1);
  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW         = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int ROW_STEP   = (IMAGE_WIDTH - KERNEL) * CHANNELS + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t             state_r;
  logic signed [15:0] line_r [LINE_DEPTH];
  logic signed [15:0] wmem_r [WDEPTH];
  logic signed [15:0] bias_r [FILTERS];
  logic [FW-1:0]      filt_r;
  logic [TW-1:0]      tap_r;
  logic [15:0]        sum_r;
  logic               iend_r;
  logic [WW-1:0]      widx_r;
  logic signed [15:0] wq_r;
  logic signed [15:0] pix_r;
  logic               zero_r;
  logic               mac_en_r;
  logic               last_tap_r;
  logic [15:0]        tot;
  logic [15:0]        res_r;
  logic [FW-1:0]      rfilt_r;
  logic               wlast_r, ilast_r;
  logic [AW-1:0]      hd_r;
  logic [NW-1:0]      fill_r;
  logic [AW-1:0]      pos_r;
  logic [CW-1:0]      tch_r;
  logic [KW-1:0]      tc_r;
  logic [AW:0]        rsum;
  logic [AW-1:0]      raddr;
  logic signed [15:0] pix_eff;
  logic               pix_wr;
  logic               last_tap;
  logic signed [31:0] prod;

  assign c_ready = (state_r == ST_IDLE);
  assign pix_wr  = c_valid && c_ready && (c_cmd.action == ACT_PIXEL);

  // circular line buffer: oldest element at hd_r, tap offset pos_r from it
  always_comb begin
    rsum     = {1'b0, hd_r} + {1'b0, pos_r};
    raddr    = (32'(rsum) >= LINE_DEPTH) ? AW'(rsum - (AW+1)'(LINE_DEPTH)) : rsum[AW-1:0];
    last_tap = (32'(tap_r) == TAPS - 1);
  end

  // entries not yet filled since reset read as zero
  assign pix_eff = zero_r ? 16'sd0 : pix_r;
  assign prod    = pix_eff * wq_r;
  assign tot     = sum_r + trunc_q(prod) + 16'(bias_r[filt_r]);

  // head pointer and fill count of the line buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r   <= '0;
      fill_r <= '0;
    end else if (pix_wr) begin
      hd_r <= (32'(hd_r) == LINE_DEPTH - 1) ? '0 : hd_r + 1'b1;
      if (32'(fill_r) < LINE_DEPTH) fill_r <= fill_r + 1'b1;
    end
  end

  // line, weight and bias stores; line and weight reads are registered
  always_ff @(posedge clk) begin
    if (pix_wr) line_r[hd_r] <= c_cmd.value;
    if (c_valid && c_ready && c_cmd.action == ACT_WEIGHT &&
        32'(c_cmd.address) < WDEPTH)
      wmem_r[c_cmd.address[WW-1:0]] <= c_cmd.value;
    if (c_valid && c_ready && c_cmd.action == ACT_BIAS &&
        32'(c_cmd.address) < FILTERS)
      bias_r[c_cmd.address[FW-1:0]] <= c_cmd.value;
    wq_r   <= wmem_r[widx_r];
    pix_r  <= line_r[raddr];
    zero_r <= (32'(pos_r) + 32'(fill_r) < LINE_DEPTH);
  end

  // mac sequencer: one tap per cycle, one filter at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_tvalid <= 1'b0;
      mac_en_r   <= 1'b0;
      last_tap_r <= 1'b0;
      filt_r <= '0; tap_r <= '0; widx_r <= '0; sum_r <= '0; iend_r <= 1'b0;
      pos_r  <= '0; tch_r <= '0; tc_r <= '0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      mac_en_r   <= 1'b0;
      last_tap_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (c_valid && c_cmd.window_ok) begin
            state_r <= ST_MAC;
            filt_r  <= '0; tap_r <= '0; sum_r <= '0; widx_r <= '0;
            pos_r   <= '0; tch_r <= '0; tc_r <= '0;
            iend_r  <= c_cmd.image_end;
          end
        end
        ST_MAC: begin
          // issue reads for this tap, accumulate the previous one
          if (!last_tap_r && !(mac_en_r && last_tap)) begin
            mac_en_r   <= 1'b1;
            last_tap_r <= last_tap;
            if (!last_tap) begin
              tap_r  <= tap_r + 1'b1;
              widx_r <= widx_r + WW'(FILTERS);
              // step channel, then kernel column, then kernel row
              if (32'(tch_r) == CHANNELS - 1) begin
                tch_r <= '0;
                if (32'(tc_r) == KERNEL - 1) begin
                  tc_r  <= '0;
                  pos_r <= pos_r + AW'(ROW_STEP);
                end else begin
                  tc_r  <= tc_r + 1'b1;
                  pos_r <= pos_r + 1'b1;
                end
              end else begin
                tch_r <= tch_r + 1'b1;
                pos_r <= pos_r + 1'b1;
              end
            end
          end
          if (mac_en_r) begin
            if (last_tap_r) begin
              res_r   <= tot;
              rfilt_r <= filt_r;
              wlast_r <= (32'(filt_r) == FILTERS - 1);
              ilast_r <= iend_r && (32'(filt_r) == FILTERS - 1);
              state_r <= ST_OUT;
            end else begin
              sum_r <= sum_r + trunc_q(prod);
            end
          end
        end
        ST_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {3'(rfilt_r), res_r[15] ? 15'd0 : res_r[14:0]};
            out_tuser  <= {ilast_r, wlast_r};
            if (wlast_r) begin
              state_r <= ST_IDLE;
            end else begin
              filt_r  <= filt_r + 1'b1;
              tap_r   <= '0; sum_r <= '0;
              pos_r   <= '0; tch_r <= '0; tc_r <= '0;
              widx_r  <= WW'(32'(filt_r) + 1);
              state_r <= ST_MAC;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/conv2d_relu_line_buffer.sv
// top level of the streaming convolution with relu
// Usage: in_* carries requests: tuser = action, tdata = {value, address}.
// Action pixel shifts one element into the line buffer; weight and bias
// actions load coefficients. When a pixel completes a KERNEL x KERNEL window,
// one result per filter leaves on out_*, filters in order.
// out_tdata holds result [14:0] and filter index [17:15]; out_tuser holds
// window_last [0] and image_last [1].
// A window request passes through the command queue to the mac sequencer.
// For each filter the single shared multiply-accumulate unit steps through
// TAPS = KERNEL*KERNEL*CHANNELS taps, then the result goes to the output
// register before the next filter starts; the sequencer takes no new request
// until the last filter's result is registered. A request that completes no
// window does not start the sequencer.
// A two-entry command queue separates request intake from the mac sequencer.
// Reset clears the raster counters, the queue and the line buffer fill count,
// so the line buffer reads as zero; weights and biases must be loaded before
// use. A stalled receiver holds the result and stops the sequencer, after
// which the queue fills and in_tready falls.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_relu_line_buffer import cnv_pkg::*; #(
  parameter int IMAGE_WIDTH = 32,
  parameter int KERNEL      = 3,
  parameter int CHANNELS    = 1,
  parameter int FILTERS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // action
  input  wire logic [31:0] in_tdata,   // address [9:0], value [25:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // result [14:0], filter_index [17:15]
  output logic [1:0]       out_tuser   // window_last [0], image_last [1]
);

  logic       fq_valid, fq_ready, bq_valid, bq_ready;
  cmd_t       fq_cmd, bq_cmd;
  logic [17:0] b_data;

  cnv_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .CHANNELS(CHANNELS), .KERNEL(KERNEL)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser,
    .in_tdata(in_tdata[25:0]),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
  );

  cnv_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_cmd(fq_cmd),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_cmd(bq_cmd)
  );

  cnv_back #(.IMAGE_WIDTH(IMAGE_WIDTH), .KERNEL(KERNEL), .CHANNELS(CHANNELS),
             .FILTERS(FILTERS)) u_back (
    .clk, .rst_n,
    .c_valid(bq_valid), .c_ready(bq_ready), .c_cmd(bq_cmd),
    .out_tvalid, .out_tready, .out_tuser(out_tuser), .out_tdata(b_data)
  );

  // pad result and filter index to whole bytes
  assign out_tdata = {6'd0, b_data};

endmodule
`default_nettype wire
